// ===== rtl/hlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HELLO line parser package
// Shared constants, state encodings and the classified byte record that
// travels from the front end through the queue to the parser back end.
// ----------------------------------------------------------------------------
package hlp_pkg;

  localparam int unsigned FieldChars = 15;
  localparam int unsigned CountW     = $clog2(FieldChars + 1);

  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam int unsigned PrefixLen  = 6;
  localparam int unsigned PrefixW    = $clog2(PrefixLen + 1);

  localparam int unsigned ValueW     = 32;

  // Character codes
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChNul   = 8'h00;

  // Side codes
  localparam logic [1:0] SideL = 2'd0;
  localparam logic [1:0] SideR = 2'd1;
  localparam logic [1:0] SideC = 2'd2;
  localparam logic [1:0] SideS = 2'd3;

  typedef enum logic [6:0] {
    PH_PREFIX     = 7'b0000001,
    PH_SIDE       = 7'b0000010,
    PH_COMMA      = 7'b0000100,
    PH_BOOT       = 7'b0001000,
    PH_BOOT_COMMA = 7'b0010000,
    PH_SESSION    = 7'b0100000,
    PH_TAIL       = 7'b1000000
  } phase_e;

  typedef enum logic [5:0] {
    NS_SPACE  = 6'b000001,
    NS_SIGNED = 6'b000010,
    NS_ZERO   = 6'b000100,
    NS_XSEEN  = 6'b001000,
    NS_DIGITS = 6'b010000,
    NS_DONE   = 6'b100000
  } num_stage_e;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_ws;
    logic       is_term;
    logic       is_sign;
    logic       is_minus;
    logic       is_comma;
    logic       is_zero;
    logic       is_x;
    logic       side_ok;
    logic [1:0] side;
  } item_t;

  function automatic logic [7:0] hello_char(input logic [PrefixW-1:0] pos);
    logic [7:0] ch;
    case (pos)
      PrefixW'(0): ch = ChH;
      PrefixW'(1): ch = ChE;
      PrefixW'(2): ch = ChL;
      PrefixW'(3): ch = ChL;
      PrefixW'(4): ch = ChO;
      PrefixW'(5): ch = ChComma;
      default:     ch = ChNul;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hlp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HELLO line parser input channel
// Valid/ready channel carrying one message byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface hlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_message;

  modport source (output valid, output byte_in, output end_of_message, input ready);
  modport sink   (input valid, input byte_in, input end_of_message, output ready);
endinterface
`default_nettype wire

// ===== rtl/hlp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HELLO line parser result channel
// Valid/ready channel carrying one parse verdict with side, boot and session.
// ----------------------------------------------------------------------------
interface hlp_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  side_code;
  logic [31:0] boot_value;
  logic [31:0] session_value;

  modport source (output valid, output accepted, output side_code, output boot_value,
                  output session_value, input ready);
  modport sink   (input valid, input accepted, input side_code, input boot_value,
                  input session_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/hello_line_parser_top.sv =====
// A final byte is queued, then popped by the back end, which registers the result.
// Throughput: 1 byte per cycle; the back end parser takes one queued byte each cycle
// and stalls only when a final byte meets a result still held in the output register.
// Reset: rst_ni (async, active low) empties the byte queue, drops any pending result
// and returns the parser to the start of a message.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HELLO line parser
// Streams a HELLO announce line and reports side, boot and session values.
// ----------------------------------------------------------------------------
module hello_line_parser_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  hlp_in_if.sink    in_i,
  hlp_out_if.source out_o
);

  hlp_pkg::item_t push_item;
  logic           push_valid;
  logic           push_ready;
  hlp_pkg::item_t pop_item;
  logic           pop_valid;
  logic           pop;

  hlp_front u_front (
    .in_i         (in_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  hlp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  hlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // a rejected message carries all-zero fields
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.accepted) |->
      ((out_o.side_code == 2'd0) && (out_o.boot_value == '0) &&
       (out_o.session_value == '0)))
    else $error("rejected result carries nonzero fields");

  // a popped final byte always lands in the output register
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pop_item.last) |=> out_o.valid)
    else $error("final byte popped without a result");

  // the back end only takes bytes that are queued
  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  // after an accepted byte, the queue offers a byte to the back end in the next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> pop_valid)
    else $error("accepted byte not queued");
`endif

endmodule
`default_nettype wire

// ===== rtl/hlp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HELLO line parser front end
// Accepts bytes and tags each with its character classes for the back end.
// ----------------------------------------------------------------------------
module hlp_front (
  hlp_in_if.sink          in_i,
  output hlp_pkg::item_t  push_item_o,
  output logic            push_valid_o,
  input  logic            push_ready_i
);

  logic [7:0] b;
  logic       is_dec;
  logic       is_low;
  logic       is_up;

  assign b      = in_i.byte_in;
  assign is_dec = (b >= hlp_pkg::ChZero) && (b <= hlp_pkg::ChNine);
  assign is_low = (b >= hlp_pkg::ChLowA) && (b <= hlp_pkg::ChLowF);
  assign is_up  = (b >= hlp_pkg::ChUpA) && (b <= hlp_pkg::ChUpF);

  always_comb begin
    push_item_o          = '0;
    push_item_o.byte_val = b;
    push_item_o.last     = in_i.end_of_message;
    push_item_o.is_hex   = is_dec || is_low || is_up;
    // letters a-f / A-F: low nibble 1..6 maps to 10..15
    push_item_o.hex_val  = is_dec ? b[3:0] : (b[3:0] + 4'd9);
    push_item_o.is_ws    = (b == hlp_pkg::ChSpace) ||
                           ((b >= hlp_pkg::ChTab) && (b <= hlp_pkg::ChCr));
    push_item_o.is_term  = (b == hlp_pkg::ChCr) || (b == hlp_pkg::ChLf) ||
                           (b == hlp_pkg::ChSpace) || (b == hlp_pkg::ChTab);
    push_item_o.is_sign  = (b == hlp_pkg::ChPlus) || (b == hlp_pkg::ChMinus);
    push_item_o.is_minus = (b == hlp_pkg::ChMinus);
    push_item_o.is_comma = (b == hlp_pkg::ChComma);
    push_item_o.is_zero  = (b == hlp_pkg::ChZero);
    push_item_o.is_x     = (b == hlp_pkg::ChLowX) || (b == hlp_pkg::ChUpX);
    push_item_o.side_ok  = 1'b1;
    case (b)
      hlp_pkg::ChL: push_item_o.side = hlp_pkg::SideL;
      hlp_pkg::ChR: push_item_o.side = hlp_pkg::SideR;
      hlp_pkg::ChC: push_item_o.side = hlp_pkg::SideC;
      hlp_pkg::ChS: push_item_o.side = hlp_pkg::SideS;
      default: begin
        push_item_o.side    = hlp_pkg::SideL;
        push_item_o.side_ok = 1'b0;
      end
    endcase
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule
`default_nettype wire

// ===== rtl/hlp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HELLO line parser item queue
// Short FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module hlp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  hlp_pkg::item_t  push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output hlp_pkg::item_t  pop_item_o,
  input  logic            pop_i
);

  hlp_pkg::item_t                  mem_q [hlp_pkg::FifoDepth];
  logic [hlp_pkg::FifoPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [hlp_pkg::FifoPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [hlp_pkg::FifoCntW-1:0]    count_q, count_d;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready_o = (count_q != hlp_pkg::FifoCntW'(hlp_pkg::FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == hlp_pkg::FifoPtrW'(hlp_pkg::FifoDepth - 1)) ? '0
                 : wr_ptr_q + hlp_pkg::FifoPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == hlp_pkg::FifoPtrW'(hlp_pkg::FifoDepth - 1)) ? '0
                 : rd_ptr_q + hlp_pkg::FifoPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + hlp_pkg::FifoCntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - hlp_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hlp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HELLO line parser back end
// Runs the line grammar and the hex field readers over classified bytes and
// holds the verdict in an output register.
// ----------------------------------------------------------------------------
module hlp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  hlp_pkg::item_t  item_i,
  output logic            pop_o,
  hlp_out_if.source       out_o
);

  hlp_pkg::phase_e               phase_q, phase_d;
  hlp_pkg::num_stage_e           stage_q, stage_d;
  logic [hlp_pkg::PrefixW-1:0]   prefix_pos_q, prefix_pos_d;
  logic [1:0]                    side_q, side_d;
  logic [hlp_pkg::CountW-1:0]    cnt_q, cnt_d;
  logic [hlp_pkg::CountW-1:0]    cnt_inc;
  logic [hlp_pkg::ValueW-1:0]    accum_q, accum_d;
  logic [hlp_pkg::ValueW-1:0]    boot_q, boot_d;
  logic                          ovf_q, ovf_d;
  logic                          neg_q, neg_d;
  logic                          seen_q, seen_d;
  logic                          failed_q, failed_d;

  // number reader step
  hlp_pkg::num_stage_e           f_stage;
  logic [hlp_pkg::ValueW-1:0]    f_acc;
  logic                          f_ovf;
  logic                          f_neg;
  logic                          f_seen;
  logic                          sign_path;
  logic                          add_dig;

  logic                          out_valid_q, out_valid_d;
  logic                          out_acc_q, out_acc_d;
  logic [1:0]                    out_side_q, out_side_d;
  logic [hlp_pkg::ValueW-1:0]    out_boot_q, out_boot_d;
  logic [hlp_pkg::ValueW-1:0]    out_sess_q, out_sess_d;
  logic                          ok;

  function automatic logic [hlp_pkg::ValueW-1:0] num_value(
    input logic                       ovf,
    input logic                       neg,
    input logic [hlp_pkg::ValueW-1:0] acc
  );
    logic [hlp_pkg::ValueW-1:0] v;
    if (ovf) begin
      v = '1;
    end else if (neg) begin
      v = '0 - acc;
    end else begin
      v = acc;
    end
    return v;
  endfunction

  assign pop_o = pop_valid_i && (!item_i.last || !out_valid_q || out_o.ready);
  assign cnt_inc = cnt_q + hlp_pkg::CountW'(1);

  always_comb begin
    f_stage   = stage_q;
    f_acc     = accum_q;
    f_ovf     = ovf_q;
    f_neg     = neg_q;
    f_seen    = seen_q;
    sign_path = 1'b0;
    add_dig   = 1'b0;
    case (stage_q)
      hlp_pkg::NS_SPACE: begin
        if (item_i.is_ws) begin
          f_stage = hlp_pkg::NS_SPACE;
        end else if (item_i.is_sign) begin
          f_stage = hlp_pkg::NS_SIGNED;
          f_neg   = item_i.is_minus;
        end else begin
          sign_path = 1'b1;
        end
      end
      hlp_pkg::NS_SIGNED: sign_path = 1'b1;
      hlp_pkg::NS_ZERO: begin
        if (item_i.is_x) begin
          f_stage = hlp_pkg::NS_XSEEN;
        end else if (item_i.is_hex) begin
          add_dig = 1'b1;
        end else begin
          f_stage = hlp_pkg::NS_DONE;
        end
      end
      hlp_pkg::NS_XSEEN, hlp_pkg::NS_DIGITS: begin
        if (item_i.is_hex) begin
          add_dig = 1'b1;
        end else begin
          f_stage = hlp_pkg::NS_DONE;
        end
      end
      default: f_stage = stage_q;
    endcase
    if (sign_path) begin
      // a leading zero counts as a digit and may open a 0x prefix
      if (item_i.is_zero) begin
        f_seen  = 1'b1;
        f_acc   = '0;
        f_stage = hlp_pkg::NS_ZERO;
      end else if (item_i.is_hex) begin
        add_dig = 1'b1;
      end else begin
        f_stage = hlp_pkg::NS_DONE;
      end
    end
    if (add_dig) begin
      f_seen  = 1'b1;
      f_stage = hlp_pkg::NS_DIGITS;
      if (ovf_q || (accum_q[hlp_pkg::ValueW-1 -: 4] != 4'd0)) begin
        f_ovf = 1'b1;
      end else begin
        f_acc = {accum_q[hlp_pkg::ValueW-5:0], item_i.hex_val};
      end
    end
  end

  always_comb begin
    phase_d      = phase_q;
    stage_d      = stage_q;
    prefix_pos_d = prefix_pos_q;
    side_d       = side_q;
    cnt_d        = cnt_q;
    accum_d      = accum_q;
    boot_d       = boot_q;
    ovf_d        = ovf_q;
    neg_d        = neg_q;
    seen_d       = seen_q;
    failed_d     = failed_q;

    if (pop_o && !failed_q) begin
      case (phase_q)
        hlp_pkg::PH_PREFIX: begin
          if (item_i.byte_val != hlp_pkg::hello_char(prefix_pos_q)) begin
            failed_d = 1'b1;
          end else begin
            prefix_pos_d = prefix_pos_q + hlp_pkg::PrefixW'(1);
            if (prefix_pos_q == hlp_pkg::PrefixW'(hlp_pkg::PrefixLen - 1)) begin
              phase_d = hlp_pkg::PH_SIDE;
            end
          end
        end
        hlp_pkg::PH_SIDE: begin
          if (item_i.side_ok) begin
            side_d  = item_i.side;
            phase_d = hlp_pkg::PH_COMMA;
          end else begin
            failed_d = 1'b1;
          end
        end
        hlp_pkg::PH_COMMA: begin
          if (item_i.is_comma) begin
            stage_d = hlp_pkg::NS_SPACE;
            accum_d = '0;
            ovf_d   = 1'b0;
            neg_d   = 1'b0;
            seen_d  = 1'b0;
            cnt_d   = '0;
            phase_d = hlp_pkg::PH_BOOT;
          end else begin
            failed_d = 1'b1;
          end
        end
        hlp_pkg::PH_BOOT, hlp_pkg::PH_BOOT_COMMA: begin
          if (item_i.is_comma) begin
            if ((cnt_q == '0) || !seen_q) begin
              failed_d = 1'b1;
            end else begin
              boot_d  = num_value(ovf_q, neg_q, accum_q);
              stage_d = hlp_pkg::NS_SPACE;
              accum_d = '0;
              ovf_d   = 1'b0;
              neg_d   = 1'b0;
              seen_d  = 1'b0;
              cnt_d   = '0;
              phase_d = hlp_pkg::PH_SESSION;
            end
          end else if (phase_q == hlp_pkg::PH_BOOT_COMMA) begin
            failed_d = 1'b1;
          end else begin
            stage_d = f_stage;
            accum_d = f_acc;
            ovf_d   = f_ovf;
            neg_d   = f_neg;
            seen_d  = f_seen;
            cnt_d   = cnt_inc;
            if (cnt_inc >= hlp_pkg::CountW'(hlp_pkg::FieldChars)) begin
              phase_d = hlp_pkg::PH_BOOT_COMMA;
            end
          end
        end
        hlp_pkg::PH_SESSION: begin
          if (item_i.is_term) begin
            phase_d = hlp_pkg::PH_TAIL;
          end else begin
            stage_d = f_stage;
            accum_d = f_acc;
            ovf_d   = f_ovf;
            neg_d   = f_neg;
            seen_d  = f_seen;
            cnt_d   = cnt_inc;
            if (cnt_inc >= hlp_pkg::CountW'(hlp_pkg::FieldChars)) begin
              phase_d = hlp_pkg::PH_TAIL;
            end
          end
        end
        default: phase_d = phase_q;
      endcase
    end

    ok = !failed_d &&
         ((phase_d == hlp_pkg::PH_SESSION) || (phase_d == hlp_pkg::PH_TAIL)) &&
         (cnt_d != '0) && seen_d;

    out_valid_d = out_valid_q && !out_o.ready;
    out_acc_d   = out_acc_q;
    out_side_d  = out_side_q;
    out_boot_d  = out_boot_q;
    out_sess_d  = out_sess_q;

    if (pop_o && item_i.last) begin
      out_valid_d = 1'b1;
      out_acc_d   = ok;
      out_side_d  = ok ? side_d : 2'd0;
      out_boot_d  = ok ? boot_d : '0;
      out_sess_d  = ok ? num_value(ovf_d, neg_d, accum_d) : '0;
      // rearm for the next message
      phase_d      = hlp_pkg::PH_PREFIX;
      stage_d      = hlp_pkg::NS_SPACE;
      prefix_pos_d = '0;
      side_d       = 2'd0;
      cnt_d        = '0;
      accum_d      = '0;
      boot_d       = '0;
      ovf_d        = 1'b0;
      neg_d        = 1'b0;
      seen_d       = 1'b0;
      failed_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= hlp_pkg::PH_PREFIX;
      stage_q      <= hlp_pkg::NS_SPACE;
      prefix_pos_q <= '0;
      side_q       <= 2'd0;
      cnt_q        <= '0;
      accum_q      <= '0;
      boot_q       <= '0;
      ovf_q        <= 1'b0;
      neg_q        <= 1'b0;
      seen_q       <= 1'b0;
      failed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      stage_q      <= stage_d;
      prefix_pos_q <= prefix_pos_d;
      side_q       <= side_d;
      cnt_q        <= cnt_d;
      accum_q      <= accum_d;
      boot_q       <= boot_d;
      ovf_q        <= ovf_d;
      neg_q        <= neg_d;
      seen_q       <= seen_d;
      failed_q     <= failed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_acc_q  <= out_acc_d;
    out_side_q <= out_side_d;
    out_boot_q <= out_boot_d;
    out_sess_q <= out_sess_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accepted      = out_acc_q;
  assign out_o.side_code     = out_side_q;
  assign out_o.boot_value    = out_boot_q;
  assign out_o.session_value = out_sess_q;

endmodule
`default_nettype wire
